FILE: hdl/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Shared types, constants and the character table of the base64url stream
// encoder.
// ----------------------------------------------------------------------------
package b64e_pkg;

  // Width of the per-message character counter (wraps at this width)
  localparam int COUNT_BITS = 16;
  // Width of the capacity register and of the reported count
  localparam int CAP_BITS   = 16;
  // Compare width: one bit above the wider of count and capacity
  localparam int CMP_BITS   = ((COUNT_BITS > CAP_BITS) ? COUNT_BITS : CAP_BITS) + 1;
  // Job queue depth and pointer width
  localparam int QDEPTH     = 4;
  localparam int QPTR_BITS  = $clog2(QDEPTH);

  // Capacity register value after reset
  localparam logic [CAP_BITS-1:0] CAP_RESET = '1;

  // Last character index inside a job
  localparam logic [1:0] LAST_TAIL1 = 2'd1;  // one leftover byte: two chars
  localparam logic [1:0] LAST_TAIL2 = 2'd2;  // two leftover bytes: three chars
  localparam logic [1:0] LAST_GROUP = 2'd3;  // full group: four chars

  // One unit of work: up to four characters from a 24-bit word
  typedef struct packed {
    logic [23:0]           word;   // sextet 0 in the top bits
    logic [1:0]            last;   // index of the final character
    logic                  fin;    // job closes the message
    logic [COUNT_BITS-1:0] base;   // characters emitted before this job
  } job_t;

  // base64url alphabet: A-Z a-z 0-9 - _
  function automatic logic [6:0] b64e_char(input logic [5:0] s);
    logic [6:0] c;
    case (s) inside
      [6'd0:6'd25]:  c = 7'(7'd65 + 7'(s));
      [6'd26:6'd51]: c = 7'(7'd71 + 7'(s));            // 'a' - 26
      [6'd52:6'd61]: c = 7'(7'(s) - 7'd4);             // '0' - 52
      6'd62:         c = 7'd45;                        // '-'
      default:       c = 7'd95;                        // '_'
    endcase
    return c;
  endfunction

endpackage

FILE: hdl/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// Accepts raw bytes, gathers groups, checks room against the capacity
// register and pushes one character job per byte that yields output.
// ----------------------------------------------------------------------------
module b64e_front import b64e_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CAP_BITS-1:0] cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          data_byte,
  input  logic                final_byte,
  input  logic                q_full,
  output logic                push,
  output job_t                push_job
);

  logic [CAP_BITS-1:0]   capacity;
  logic [1:0]            phase, phase_next;
  logic [15:0]           held, held_next;
  logic [COUNT_BITS-1:0] count, count_next;
  logic                  stopped, stopped_next;

  logic                  accept;
  logic                  grp_ok, tail_ok;
  logic [1:0]            phase_mid;
  logic [15:0]           held_mid;
  logic [COUNT_BITS-1:0] count_mid;
  logic                  stop_mid;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // Classify the byte: group completion, then tail flush on the final byte
  always_comb begin
    grp_ok    = 1'b0;
    tail_ok   = 1'b0;
    push_job  = '0;
    push_job.base = count;
    push_job.fin  = final_byte;
    if (phase == 2'd2) begin
      grp_ok    = !stopped &&
                  (CMP_BITS'(count) + CMP_BITS'(4) < CMP_BITS'(capacity));
      phase_mid = 2'd0;
      held_mid  = '0;
      stop_mid  = stopped || !grp_ok;
      count_mid = grp_ok ? COUNT_BITS'(count + COUNT_BITS'(4)) : count;
      push_job.word = {held, data_byte};
      push_job.last = LAST_GROUP;
    end else begin
      phase_mid = phase + 2'd1;
      held_mid  = {held[7:0], data_byte};
      stop_mid  = stopped;
      count_mid = count;
    end

    if (final_byte) begin
      tail_ok = (phase_mid != 2'd0) && !stop_mid &&
                (CMP_BITS'(count_mid) + CMP_BITS'(3) < CMP_BITS'(capacity));
      if (phase_mid == 2'd1) begin
        push_job.word = {held_mid[7:0], 16'd0};
        push_job.last = LAST_TAIL1;
      end else if (phase_mid == 2'd2) begin
        push_job.word = {held_mid, 8'd0};
        push_job.last = LAST_TAIL2;
      end
      phase_next   = 2'd0;
      held_next    = '0;
      count_next   = '0;
      stopped_next = 1'b0;
    end else begin
      phase_next   = phase_mid;
      held_next    = held_mid;
      count_next   = count_mid;
      stopped_next = stop_mid;
    end

    push = accept && (grp_ok || tail_ok);
  end

  // Group state and capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
      phase    <= '0;
      held     <= '0;
      count    <= '0;
      stopped  <= 1'b0;
    end else begin
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
      if (accept) begin
        phase   <= phase_next;
        held    <= held_next;
        count   <= count_next;
        stopped <= stopped_next;
      end
    end
  end

endmodule

FILE: hdl/b64e_queue.sv
// ----------------------------------------------------------------------------
// b64e_queue
// Small job queue between classification and character output.
// ----------------------------------------------------------------------------
module b64e_queue import b64e_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  job_t                 entries [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QPTR_BITS:0]   fill;
  logic                 do_push, do_pop;

  assign full       = (fill == (QPTR_BITS+1)'(QDEPTH));
  assign head_valid = (fill != '0);
  assign head_job   = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPTR_BITS'(1);
      if (do_pop)  rd_ptr <= rd_ptr + QPTR_BITS'(1);
      case ({do_push, do_pop})
        2'b10:   fill <= fill + (QPTR_BITS+1)'(1);
        2'b01:   fill <= fill - (QPTR_BITS+1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: hdl/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// Walks each job into the output register, one char per cycle unless stalled.
// ----------------------------------------------------------------------------
module b64e_back import b64e_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        head_valid,
  input  job_t        head_job,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [6:0]  code_char,
  output logic        run_last,
  output logic        message_end,
  output logic [15:0] chars_so_far
);

  logic [1:0]                     idx;
  logic                           load, at_last;
  logic [5:0]                     sextet;
  logic [COUNT_BITS-1:0]          cnt;
  logic [COUNT_BITS+CAP_BITS-1:0] cnt_wide;

  assign load    = head_valid && (!out_valid || !out_stall);
  assign at_last = (idx == head_job.last);
  assign pop     = load && at_last;

  // Pick the current sextet of the job word
  always_comb begin
    case (idx)
      2'd0:    sextet = head_job.word[23:18];
      2'd1:    sextet = head_job.word[17:12];
      2'd2:    sextet = head_job.word[11:6];
      default: sextet = head_job.word[5:0];
    endcase
  end

  assign cnt      = COUNT_BITS'(head_job.base + COUNT_BITS'(idx) + COUNT_BITS'(1));
  assign cnt_wide = {{CAP_BITS{1'b0}}, cnt};

  // Character index within the job
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (load) begin
      idx <= at_last ? 2'd0 : idx + 2'd1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      code_char    <= b64e_char(sextet);
      run_last     <= at_last;
      message_end  <= at_last && head_job.fin;
      chars_so_far <= cnt_wide[15:0];
    end
  end

endmodule

FILE: hdl/base64url_stream_encoder_core.sv
// ----------------------------------------------------------------------------
// base64url_stream_encoder_core
// base64url encoder without padding: bytes in, one character per transfer out.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one data_byte per transfer, with
//   final_byte set on the last byte of a message. Output channel (out_valid/
//   out_stall) carries one character per transfer with run_last, message_end
//   and the running chars_so_far count.
//   Every third byte yields four characters; the final byte flushes two or
//   three tail characters. A group or tail that does not leave a terminator
//   slot in output_capacity is dropped and stops output until message end.
//   A byte's first character goes from front classify into the queue, then
//   from the queue head into the output register; the rest follow one per
//   cycle while out_stall is low. The output side moves one character per
//   cycle under the same condition, and the four-entry job queue lets input
//   continue while the output side drains a group.
//   Reset (synchronous) clears group state, the queue and the output register
//   and sets output_capacity to 65535. When the receiver stalls, the current
//   character holds, the queue fills and in_stall rises once it is full.
//   cfg_we writes output_capacity; write it only while the block is idle.
// ----------------------------------------------------------------------------
module base64url_stream_encoder_core import b64e_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CAP_BITS-1:0] cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          data_byte,
  input  logic                final_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [6:0]          code_char,
  output logic                run_last,
  output logic                message_end,
  output logic [15:0]         chars_so_far
);

  logic push, q_full, pop, head_valid;
  job_t push_job, head_job;

  // Front: byte gathering and room check
  b64e_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .data_byte  (data_byte),
    .final_byte (final_byte),
    .q_full     (q_full),
    .push       (push),
    .push_job   (push_job)
  );

  // Job queue
  b64e_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // Back: character output
  b64e_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_job     (head_job),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .code_char    (code_char),
    .run_last     (run_last),
    .message_end  (message_end),
    .chars_so_far (chars_so_far)
  );

endmodule
